// ----- hdl/lcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_pkg
// shared widths, register indexes and control structs for the fir chain
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int VALUE_W     = 34;
  localparam int TAP_COUNT_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register map
  localparam int REG_TAP_COUNT = 0;
  localparam int REG_COEF_BASE = 1;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic advance;   // pipeline moves this cycle
    logic shift;     // a sample (or flush zero) enters the row
    logic clear;     // last push of a sequence: empty the delay line
  } cell_ctrl_t;

  // sideband travelling with each result through the adder tree
  typedef struct packed {
    logic valid;
    logic done;
  } tag_t;

endpackage
`default_nettype wire

// ----- hdl/lcf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_cell
// one fir tap: holds its coefficient and one delay stage, registers a product
// ----------------------------------------------------------------------------
module lcf_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lcf_pkg::cell_ctrl_t                    ctrl,
  input  wire logic                                   coef_write,
  input  wire logic signed [lcf_pkg::COEF_W-1:0]      coef_data,
  input  wire logic                                   tap_enable,
  input  wire logic signed [lcf_pkg::SAMPLE_W-1:0]    x_in,
  output logic signed      [lcf_pkg::SAMPLE_W-1:0]    x_out,
  output logic signed      [lcf_pkg::PROD_W-1:0]      prod
);

  logic signed [lcf_pkg::COEF_W-1:0]   coef;
  logic signed [lcf_pkg::SAMPLE_W-1:0] tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      tap  <= '0;
    end else begin
      if (coef_write) begin
        coef <= coef_data;
      end
      if (ctrl.advance && ctrl.shift) begin
        tap <= ctrl.clear ? '0 : x_in;
      end
    end
  end

  // product of this tap, zero when the tap is beyond the active count
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      if (tap_enable) begin
        prod <= coef * x_in;
      end else begin
        prod <= '0;
      end
    end
  end

  assign x_out = tap;

endmodule
`default_nettype wire

// ----- hdl/lcf_sum_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcf_sum_tree
// registered binary adder tree over the cell products (a single leaf passes straight through), tag carried alongside
// ----------------------------------------------------------------------------
module lcf_sum_tree #(
  parameter int NUM_LEAVES = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire lcf_pkg::tag_t                       tag_in,
  input  wire logic signed [lcf_pkg::PROD_W-1:0]   leaf [0:NUM_LEAVES-1],
  output lcf_pkg::tag_t                            tag_out,
  output logic signed      [lcf_pkg::VALUE_W-1:0]  sum
);

  localparam int LEVELS = (NUM_LEAVES > 1) ? $clog2(NUM_LEAVES) : 0;
  localparam int NL     = 1 << LEVELS;
  localparam int EXT_W  = lcf_pkg::VALUE_W - lcf_pkg::PROD_W;

  // leaves widened to the output width, padding leaves read as zero
  logic signed [lcf_pkg::VALUE_W-1:0] leaf_ext [0:NL-1];
  lcf_pkg::tag_t                      tag      [0:LEVELS];

  for (genvar j = 0; j < NL; j++) begin : g_leaf
    if (j < NUM_LEAVES) begin : g_used
      assign leaf_ext[j] = {{EXT_W{leaf[j][lcf_pkg::PROD_W-1]}}, leaf[j]};
    end else begin : g_pad
      assign leaf_ext[j] = '0;
    end
  end

  if (LEVELS == 0) begin : g_flat
    assign sum = leaf_ext[0];
  end else begin : g_tree
    // heap layout: node 1 is the root, children of node i are 2i and 2i+1
    logic signed [lcf_pkg::VALUE_W-1:0] node [1:NL-1];

    // sums wrap at the output width, which is what the result wants anyway
    for (genvar i = 1; i < NL; i++) begin : g_node
      if (2 * i >= NL) begin : g_low
        always_ff @(posedge clk) begin
          if (advance) begin
            node[i] <= leaf_ext[2*i-NL] + leaf_ext[2*i+1-NL];
          end
        end
      end else begin : g_high
        always_ff @(posedge clk) begin
          if (advance) begin
            node[i] <= node[2*i] + node[2*i+1];
          end
        end
      end
    end

    assign sum = node[1];
  end

  // stage 0 lines up with the product registers inside the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else if (advance) begin
      tag[0] <= tag_in;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[l] <= '0;
      end else if (advance) begin
        tag[l] <= tag[l-1];
      end
    end
  end

  assign tag_out = tag[LEVELS];

endmodule
`default_nettype wire

// ----- hdl/linear_convolution_fir_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_convolution_fir_top
// streaming direct-form fir giving the full linear convolution of a sample
// sequence with up to MAX_TAPS coefficients, tail flushed on the final sample
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------
//  sample in | sample_valid / sample_stall | sample[15:0] s, final_sample
//  conv out  | conv_valid / conv_stall     | conv_value[33:0] s, conv_done
//  config    | cfg_write                   | cfg_index, cfg_data[15:0]
//
//  one sample per clock unless stalled; a final sample also arms a zero tail,
//  one push fewer than the clamped tap count, pushed through the cell row
//  (input stalled then); each result is registered by the product register in
//  each cell and then at each level of the adder tree
//  synchronous reset clears delay line, coefficients, tap_count (to 1), tags
//  a stalled output freezes the whole pipe, which then stalls the input
// ----------------------------------------------------------------------------
module linear_convolution_fir_top #(
  parameter int MAX_TAPS = 6
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // config
  input  wire logic                                      cfg_write,
  input  wire logic [$clog2(MAX_TAPS + 1)-1:0]           cfg_index,
  input  wire logic [lcf_pkg::CFG_DATA_W-1:0]            cfg_data,
  // sample in
  input  wire logic                                      sample_valid,
  output logic                                           sample_stall,
  input  wire logic signed [lcf_pkg::SAMPLE_W-1:0]       sample,
  input  wire logic                                      final_sample,
  // convolution out
  output logic                                           conv_valid,
  input  wire logic                                      conv_stall,
  output logic signed [lcf_pkg::VALUE_W-1:0]             conv_value,
  output logic                                           conv_done
);

  localparam int IDX_W   = $clog2(MAX_TAPS + 1);
  localparam int CNT_RAW = $clog2(MAX_TAPS + 1);
  localparam int CNT_W   = (CNT_RAW > lcf_pkg::TAP_COUNT_W) ? CNT_RAW
                                                             : lcf_pkg::TAP_COUNT_W;

  // ---------------------------------------------------------------- config
  logic [lcf_pkg::TAP_COUNT_W-1:0] tap_count;
  logic [CNT_W-1:0]                tc_ext;
  logic [CNT_W-1:0]                act;     // taps in use after clamping

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= lcf_pkg::TAP_COUNT_W'(1);
    end else if (cfg_write && cfg_index == IDX_W'(lcf_pkg::REG_TAP_COUNT)) begin
      tap_count <= cfg_data[lcf_pkg::TAP_COUNT_W-1:0];
    end
  end

  // zero counts as one tap, anything above the cell count saturates
  always_comb begin
    tc_ext = CNT_W'(tap_count);
    if (tc_ext == '0) begin
      act = CNT_W'(1);
    end else if (tc_ext > CNT_W'(MAX_TAPS)) begin
      act = CNT_W'(MAX_TAPS);
    end else begin
      act = tc_ext;
    end
  end

  // ------------------------------------------------------------- sequencer
  logic                 en;           // pipeline advances
  logic [CNT_W-1:0]     flush_left;   // zero pushes still owed to the tail
  logic [CNT_W-1:0]     flush_left_next;
  logic                 flushing;
  logic                 accept;
  logic                 push_valid;
  logic                 push_done;
  logic                 push_clear;
  logic signed [lcf_pkg::SAMPLE_W-1:0] push_x;
  lcf_pkg::cell_ctrl_t  ctrl;
  lcf_pkg::tag_t        push_tag;
  lcf_pkg::tag_t        out_tag;

  assign en           = !conv_valid || !conv_stall;
  assign flushing     = (flush_left != '0);
  assign sample_stall = !en || flushing;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    push_valid = en && (flushing || sample_valid);
    push_x     = flushing ? '0 : sample;
    if (flushing) begin
      // last zero of the tail closes the sequence
      push_done  = (flush_left == CNT_W'(1));
      push_clear = (flush_left == CNT_W'(1));
    end else begin
      // single tap: the final sample's own output closes it
      push_done  = final_sample && (act == CNT_W'(1));
      push_clear = final_sample && (act == CNT_W'(1));
    end
  end

  always_comb begin
    flush_left_next = flush_left;
    if (en) begin
      if (flushing) begin
        flush_left_next = flush_left - CNT_W'(1);
      end else if (accept && final_sample && act != CNT_W'(1)) begin
        flush_left_next = act - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_left <= '0;
    end else begin
      flush_left <= flush_left_next;
    end
  end

  assign ctrl     = '{advance: en, shift: push_valid, clear: push_clear};
  assign push_tag = '{valid: push_valid, done: push_done};

  // -------------------------------------------------------------- cell row
  // taps[k] feeds cell k: the incoming push for cell 0, the delay of the
  // left neighbour otherwise
  logic signed [lcf_pkg::SAMPLE_W-1:0] taps  [0:MAX_TAPS];
  logic signed [lcf_pkg::PROD_W-1:0]   prods [0:MAX_TAPS-1];

  assign taps[0] = push_x;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    lcf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .coef_write (cfg_write && cfg_index == IDX_W'(lcf_pkg::REG_COEF_BASE + k)),
      .coef_data  (cfg_data),
      .tap_enable (CNT_W'(k) < act),
      .x_in       (taps[k]),
      .x_out      (taps[k+1]),
      .prod       (prods[k])
    );
  end

  // ------------------------------------------------------------ adder tree
  lcf_sum_tree #(
    .NUM_LEAVES (MAX_TAPS)
  ) u_tree (
    .clk     (clk),
    .rst     (rst),
    .advance (en),
    .tag_in  (push_tag),
    .leaf    (prods),
    .tag_out (out_tag),
    .sum     (conv_value)
  );

  assign conv_valid = out_tag.valid;
  assign conv_done  = out_tag.done;

  // ------------------------------------------------------------ assertions
  // a final sample with more than one tap arms a tail of act-1 zero pushes
  a_flush_armed: assert property (@(posedge clk) disable iff (rst)
    (accept && final_sample && act > CNT_W'(1)) |=> flush_left == $past(act - CNT_W'(1)))
    else $error("tail length not armed from tap count");

  // no new sample slips in while the tail is still being pushed
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !accept)
    else $error("sample transaction taken during tail flush");

  // closing push leaves the delay line empty (checked on the first stage)
  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_clear) |=> taps[1] == '0)
    else $error("delay line not cleared at end of sequence");

  // the tail counter never exceeds the cell count minus one
  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    flush_left < CNT_W'(MAX_TAPS))
    else $error("tail counter out of range");

endmodule
`default_nettype wire
